// ===== hw/rtl/pimbm_pkg.sv =====
package pimbm_pkg;

   localparam int ADDR_W    = 32;
   localparam int SEC_W     = 32;
   localparam int USEC_W    = 20;
   localparam int MS_W      = 10;
   localparam int LEN_W     = 16;
   localparam int HDR_W     = 4;
   localparam int BYTES_W   = 32;
   localparam int PKTS_W    = 24;
   localparam int TOTAL_W   = 48;

   // minimum IPv4 header: 20 bytes = 5 words of 4 bytes
   localparam logic [HDR_W-1:0] MIN_HEADER_WORDS = HDR_W'(20 / 4);

   // floor(us / 1000) = (us * ceil(2^30 / 1000)) >> 30, exact for 20-bit us
   localparam int USEC_PER_MS = 1000;
   localparam int MS_SHIFT    = 30;
   localparam int MS_RECIP_W  = 21;
   localparam logic [MS_RECIP_W-1:0] MS_RECIP =
      MS_RECIP_W'(((64'd1 << MS_SHIFT) + USEC_PER_MS - 1) / USEC_PER_MS);
   localparam int MS_PROD_W   = USEC_W + MS_RECIP_W;
   localparam int MS_QUOT_W   = MS_PROD_W - MS_SHIFT;
   localparam logic [MS_W-1:0] MAX_MS = MS_W'(USEC_PER_MS - 1);

   typedef enum logic {
      ACTION_PACKET = 1'b0,
      ACTION_FLUSH  = 1'b1
   } action_type;

   typedef struct packed {
      action_type        action;
      logic [SEC_W-1:0]  seconds;
      logic [MS_W-1:0]   millis;
      logic [LEN_W-1:0]  wire_length;
      logic [HDR_W-1:0]  header_words;
      logic [ADDR_W-1:0] destination_address;
   } item_type;

   typedef struct packed {
      logic [SEC_W-1:0]   record_seconds;
      logic [MS_W-1:0]    record_millis;
      logic [BYTES_W-1:0] record_bytes;
      logic [PKTS_W-1:0]  record_packets;
      logic [BYTES_W-1:0] peak_bytes;
      logic [PKTS_W-1:0]  peak_packets;
      logic [TOTAL_W-1:0] seen_packets;
      logic [TOTAL_W-1:0] seen_incoming;
   } record_type;

endpackage

// ===== hw/rtl/pimbm_if.sv =====
interface pimbm_req_if import pimbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [SEC_W-1:0]  time_seconds;
   logic [USEC_W-1:0] time_microseconds;
   logic [LEN_W-1:0]  wire_length;
   logic [HDR_W-1:0]  header_words;
   logic [ADDR_W-1:0] destination_address;

   modport source (
      output valid, action, time_seconds, time_microseconds, wire_length,
             header_words, destination_address,
      input  ready
   );
   modport sink (
      input  valid, action, time_seconds, time_microseconds, wire_length,
             header_words, destination_address,
      output ready
   );
endinterface

interface pimbm_rsp_if import pimbm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SEC_W-1:0]   record_seconds;
   logic [MS_W-1:0]    record_millis;
   logic [BYTES_W-1:0] record_bytes;
   logic [PKTS_W-1:0]  record_packets;
   logic [BYTES_W-1:0] peak_bytes;
   logic [PKTS_W-1:0]  peak_packets;
   logic [TOTAL_W-1:0] seen_packets;
   logic [TOTAL_W-1:0] seen_incoming;

   modport source (
      output valid, record_seconds, record_millis, record_bytes, record_packets,
             peak_bytes, peak_packets, seen_packets, seen_incoming,
      input  ready
   );
   modport sink (
      input  valid, record_seconds, record_millis, record_bytes, record_packets,
             peak_bytes, peak_packets, seen_packets, seen_incoming,
      output ready
   );
endinterface

// ===== hw/rtl/pimbm_accum.sv =====
module pimbm_accum import pimbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  item_type          item,
   input  logic [ADDR_W-1:0] local_address,
   output logic              emit,
   output record_type        record
);

   logic               bin_open_ff, bin_open_in;
   logic [SEC_W-1:0]   bin_seconds_ff, bin_seconds_in;
   logic [MS_W-1:0]    bin_millis_ff, bin_millis_in;
   logic [BYTES_W-1:0] bin_bytes_ff, bin_bytes_in;
   logic [PKTS_W-1:0]  bin_packets_ff, bin_packets_in;
   logic [BYTES_W-1:0] top_bytes_ff, top_bytes_in;
   logic [PKTS_W-1:0]  top_packets_ff, top_packets_in;
   logic [TOTAL_W-1:0] count_all_ff, count_all_in;
   logic [TOTAL_W-1:0] count_incoming_ff, count_incoming_in;

   logic               incoming;
   logic               same_bin;
   logic [BYTES_W:0]   byte_sum;
   logic [BYTES_W-1:0] peak_bytes;
   logic [PKTS_W-1:0]  peak_packets;

   assign incoming     = (item.destination_address == local_address);
   assign same_bin     = bin_open_ff && (bin_seconds_ff == item.seconds)
                         && (bin_millis_ff == item.millis);
   assign byte_sum     = {1'b0, bin_bytes_ff} + {{(BYTES_W + 1 - LEN_W){1'b0}}, item.wire_length};
   assign peak_bytes   = (bin_bytes_ff > top_bytes_ff) ? bin_bytes_ff : top_bytes_ff;
   assign peak_packets = (bin_packets_ff > top_packets_ff) ? bin_packets_ff : top_packets_ff;

   always_comb begin
      bin_open_in       = bin_open_ff;
      bin_seconds_in    = bin_seconds_ff;
      bin_millis_in     = bin_millis_ff;
      bin_bytes_in      = bin_bytes_ff;
      bin_packets_in    = bin_packets_ff;
      top_bytes_in      = top_bytes_ff;
      top_packets_in    = top_packets_ff;
      count_all_in      = count_all_ff;
      count_incoming_in = count_incoming_ff;
      emit              = 1'b0;
      if (item.action == ACTION_FLUSH) begin
         if (bin_open_ff) begin
            emit           = 1'b1;
            bin_open_in    = 1'b0;
            bin_bytes_in   = '0;
            bin_packets_in = '0;
         end
      end else if (item.header_words >= MIN_HEADER_WORDS) begin
         if (count_all_ff != '1) begin
            count_all_in = count_all_ff + TOTAL_W'(1);
         end
         if (incoming) begin
            if (count_incoming_ff != '1) begin
               count_incoming_in = count_incoming_ff + TOTAL_W'(1);
            end
            if (same_bin) begin
               bin_bytes_in = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
               if (bin_packets_ff != '1) begin
                  bin_packets_in = bin_packets_ff + PKTS_W'(1);
               end
            end else begin
               emit           = bin_open_ff;
               bin_open_in    = 1'b1;
               bin_seconds_in = item.seconds;
               bin_millis_in  = item.millis;
               bin_bytes_in   = BYTES_W'(item.wire_length);
               bin_packets_in = PKTS_W'(1);
            end
         end
      end
      if (emit) begin
         top_bytes_in   = peak_bytes;
         top_packets_in = peak_packets;
      end
   end

   always_comb begin
      record.record_seconds = bin_seconds_ff;
      record.record_millis  = bin_millis_ff;
      record.record_bytes   = bin_bytes_ff;
      record.record_packets = bin_packets_ff;
      record.peak_bytes     = peak_bytes;
      record.peak_packets   = peak_packets;
      record.seen_packets   = count_all_in;
      record.seen_incoming  = count_incoming_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_open_ff       <= 1'b0;
         bin_seconds_ff    <= '0;
         bin_millis_ff     <= '0;
         bin_bytes_ff      <= '0;
         bin_packets_ff    <= '0;
         top_bytes_ff      <= '0;
         top_packets_ff    <= '0;
         count_all_ff      <= '0;
         count_incoming_ff <= '0;
      end else if (step) begin
         bin_open_ff       <= bin_open_in;
         bin_seconds_ff    <= bin_seconds_in;
         bin_millis_ff     <= bin_millis_in;
         bin_bytes_ff      <= bin_bytes_in;
         bin_packets_ff    <= bin_packets_in;
         top_bytes_ff      <= top_bytes_in;
         top_packets_ff    <= top_packets_in;
         count_all_ff      <= count_all_in;
         count_incoming_ff <= count_incoming_in;
      end
   end

endmodule

// ===== hw/rtl/per_millisecond_ingress_burst_meter_core.sv =====
// Per-millisecond ingress burst meter. Each req word is a packet descriptor or
// a flush. Packets with an IPv4 header under 20 bytes are dropped uncounted;
// packets to csr_write_data's local address are summed into a millisecond bin,
// and the closed bin goes out on rsp with the running peaks and totals when a
// packet lands in a new millisecond or on a flush. Throughput is one word per
// clock while rsp is not stalled. The req word closing a bin goes into the
// input register (the microsecond-to-millisecond multiply sits ahead of it),
// and its record into the result register as it advances. A stalled rsp holds
// the input register and so req. Write the local address only while idle.
module per_millisecond_ingress_burst_meter_core import pimbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [ADDR_W-1:0] csr_write_data,
   pimbm_req_if.sink         req,
   pimbm_rsp_if.source       rsp
);

   logic [ADDR_W-1:0]    local_address_ff;
   logic                 in_valid_ff;
   item_type             item_ff, item_in;
   logic                 rsp_valid_ff;
   record_type           rsp_data_ff;

   logic [MS_PROD_W-1:0] ms_product;
   logic [MS_QUOT_W-1:0] ms_quotient;
   logic                 accept;
   logic                 advance;
   logic                 emit;
   record_type           record;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !reset && (!in_valid_ff || advance);
   assign accept    = req.valid && req.ready;

   assign ms_product  = MS_PROD_W'(req.time_microseconds) * MS_PROD_W'(MS_RECIP);
   assign ms_quotient = ms_product[MS_PROD_W-1:MS_SHIFT];

   always_comb begin
      item_in.action              = action_type'(req.action);
      item_in.seconds             = req.time_seconds;
      item_in.millis              = (ms_quotient > MS_QUOT_W'(MAX_MS)) ? MAX_MS
                                                                       : ms_quotient[MS_W-1:0];
      item_in.wire_length         = req.wire_length;
      item_in.header_words        = req.header_words;
      item_in.destination_address = req.destination_address;
   end

   pimbm_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (item_ff),
      .local_address (local_address_ff),
      .emit          (emit),
      .record        (record)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            local_address_ff <= csr_write_data;
         end
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= emit;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance && emit) begin
         rsp_data_ff <= record;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.record_seconds = rsp_data_ff.record_seconds;
   assign rsp.record_millis  = rsp_data_ff.record_millis;
   assign rsp.record_bytes   = rsp_data_ff.record_bytes;
   assign rsp.record_packets = rsp_data_ff.record_packets;
   assign rsp.peak_bytes     = rsp_data_ff.peak_bytes;
   assign rsp.peak_packets   = rsp_data_ff.peak_packets;
   assign rsp.seen_packets   = rsp_data_ff.seen_packets;
   assign rsp.seen_incoming  = rsp_data_ff.seen_incoming;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import pimbm_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_WORDS    = 262;
   localparam int BURST_WORDS    = 16;

   typedef struct {
      action_type        action;
      logic [SEC_W-1:0]  seconds;
      logic [USEC_W-1:0] microseconds;
      logic [LEN_W-1:0]  wire_length;
      logic [HDR_W-1:0]  header_words;
      logic [ADDR_W-1:0] destination_address;
   } packet_word_type;

   class bin_meter_scoreboard;
      logic [ADDR_W-1:0]  local_addr = '0;
      logic               bin_open = 1'b0;
      logic [SEC_W-1:0]   bin_secs = '0;
      logic [MS_W-1:0]    bin_ms = '0;
      logic [BYTES_W-1:0] bin_bytes = '0;
      logic [PKTS_W-1:0]  bin_pkts = '0;
      logic [BYTES_W-1:0] peak_bytes = '0;
      logic [PKTS_W-1:0]  peak_pkts = '0;
      logic [TOTAL_W-1:0] total_all = '0;
      logic [TOTAL_W-1:0] total_in = '0;
      record_type         due_records[$];
      int                 failures = 0;

      function void set_local_address(logic [ADDR_W-1:0] addr);
         local_addr = addr;
      endfunction

      function int pending_count();
         return due_records.size();
      endfunction

      function void note_word(packet_word_type w);
         record_type         rec;
         logic               closed;
         int unsigned        ms_full;
         logic [MS_W-1:0]    ms;
         logic [BYTES_W:0]   sum;
         closed = 1'b0;
         if (w.action == ACTION_FLUSH) begin
            if (!bin_open)
               return;
            closed = 1'b1;
            rec.record_seconds = bin_secs;
            rec.record_millis  = bin_ms;
            rec.record_bytes   = bin_bytes;
            rec.record_packets = bin_pkts;
            bin_open  = 1'b0;
            bin_bytes = '0;
            bin_pkts  = '0;
         end else begin
            if (w.header_words < MIN_HEADER_WORDS)
               return;
            ms_full = w.microseconds / USEC_PER_MS;
            ms = (ms_full > MAX_MS) ? MAX_MS : MS_W'(ms_full);
            if (w.destination_address == local_addr) begin
               if (bin_open && bin_secs == w.seconds && bin_ms == ms) begin
                  sum = {1'b0, bin_bytes} + (BYTES_W + 1)'(w.wire_length);
                  bin_bytes = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                  if (bin_pkts != '1)
                     bin_pkts++;
               end else begin
                  if (bin_open) begin
                     closed = 1'b1;
                     rec.record_seconds = bin_secs;
                     rec.record_millis  = bin_ms;
                     rec.record_bytes   = bin_bytes;
                     rec.record_packets = bin_pkts;
                  end
                  bin_open  = 1'b1;
                  bin_secs  = w.seconds;
                  bin_ms    = ms;
                  bin_bytes = BYTES_W'(w.wire_length);
                  bin_pkts  = PKTS_W'(1);
               end
               if (total_in != '1)
                  total_in++;
            end
            if (total_all != '1)
               total_all++;
         end
         if (!closed)
            return;
         if (rec.record_bytes > peak_bytes)
            peak_bytes = rec.record_bytes;
         if (rec.record_packets > peak_pkts)
            peak_pkts = rec.record_packets;
         rec.peak_bytes    = peak_bytes;
         rec.peak_packets  = peak_pkts;
         rec.seen_packets  = total_all;
         rec.seen_incoming = total_in;
         due_records.push_back(rec);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_record(record_type got);
         record_type want;
         if (due_records.size() == 0) begin
            $error("unexpected record: seconds %0h millis %0d bytes %0h",
                   got.record_seconds, got.record_millis, got.record_bytes);
            failures++;
            return;
         end
         want = due_records.pop_front();
         compare_field("record_seconds", want.record_seconds, got.record_seconds);
         compare_field("record_millis", want.record_millis, got.record_millis);
         compare_field("record_bytes", want.record_bytes, got.record_bytes);
         compare_field("record_packets", want.record_packets, got.record_packets);
         compare_field("peak_bytes", want.peak_bytes, got.peak_bytes);
         compare_field("peak_packets", want.peak_packets, got.peak_packets);
         compare_field("seen_packets", want.seen_packets, got.seen_packets);
         compare_field("seen_incoming", want.seen_incoming, got.seen_incoming);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [ADDR_W-1:0] csr_write_data = '0;

   pimbm_req_if req_bus ();
   pimbm_rsp_if rsp_bus ();

   per_millisecond_ingress_burst_meter_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_bus),
      .rsp              (rsp_bus)
   );

   bin_meter_scoreboard sb;
   logic [ADDR_W-1:0]   local_addr_now = '0;
   logic [SEC_W-1:0]    now_secs = '0;
   int unsigned         now_ms = 0;
   logic                idle_on = 1'b1;
   logic                stall_on = 1'b1;
   int                  quiet_cycles = 0;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic packet_word_type make_packet(logic [SEC_W-1:0] secs,
                                                   logic [USEC_W-1:0] usec,
                                                   logic [LEN_W-1:0] len,
                                                   logic [HDR_W-1:0] hdr,
                                                   logic [ADDR_W-1:0] dst);
      packet_word_type w;
      w.action              = ACTION_PACKET;
      w.seconds             = secs;
      w.microseconds        = usec;
      w.wire_length         = len;
      w.header_words        = hdr;
      w.destination_address = dst;
      return w;
   endfunction

   function automatic packet_word_type make_flush();
      packet_word_type w;
      w = make_packet($urandom(), USEC_W'($urandom()), LEN_W'($urandom()),
                      HDR_W'($urandom()), $urandom());
      w.action = ACTION_FLUSH;
      return w;
   endfunction

   // mostly in-order incoming traffic on a running timeline, plus flushes and noise
   function automatic packet_word_type random_word();
      packet_word_type w;
      int              r;
      w = make_packet($urandom(), USEC_W'($urandom()), LEN_W'($urandom()),
                      HDR_W'($urandom()), $urandom());
      r = $urandom_range(0, 99);
      if (r < 6)
         return make_flush();
      if (r < 20)
         return w;
      if (r < 27) begin
         w.destination_address = local_addr_now ^ (32'd1 << $urandom_range(0, 31));
         return w;
      end
      r = $urandom_range(0, 99);
      if (r >= 55 && r < 85) begin
         now_ms = now_ms + $urandom_range(1, 3);
      end else if (r >= 85 && r < 95) begin
         now_secs++;
         now_ms = $urandom_range(0, 999);
      end else if (r >= 95) begin
         now_secs = $urandom();
         now_ms = $urandom_range(0, 999);
      end
      if (now_ms > 999) begin
         now_ms = now_ms - 1000;
         now_secs++;
      end
      w.seconds = now_secs;
      if (now_ms == 999 && $urandom_range(0, 1) == 1)
         w.microseconds = USEC_W'($urandom_range(999000, 1048575));
      else
         w.microseconds = USEC_W'(now_ms * 1000 + $urandom_range(0, 999));
      w.header_words = HDR_W'($urandom_range(5, 15));
      w.destination_address = local_addr_now;
      return w;
   endfunction

   task automatic send_word(packet_word_type w);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.action              <= w.action;
      req_bus.time_seconds        <= w.seconds;
      req_bus.time_microseconds   <= w.microseconds;
      req_bus.wire_length         <= w.wire_length;
      req_bus.header_words        <= w.header_words;
      req_bus.destination_address <= w.destination_address;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_for_records();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_local_address(logic [ADDR_W-1:0] addr);
      csr_write_enable <= 1'b1;
      csr_write_data   <= addr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_local_address(addr);
      local_addr_now = addr;
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         int stall;
         stall = stall_on ? pick_gap() : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : monitor
      record_type      got;
      packet_word_type seen;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.record_seconds = rsp_bus.record_seconds;
            got.record_millis  = rsp_bus.record_millis;
            got.record_bytes   = rsp_bus.record_bytes;
            got.record_packets = rsp_bus.record_packets;
            got.peak_bytes     = rsp_bus.peak_bytes;
            got.peak_packets   = rsp_bus.peak_packets;
            got.seen_packets   = rsp_bus.seen_packets;
            got.seen_incoming  = rsp_bus.seen_incoming;
            sb.check_record(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.action              = action_type'(req_bus.action);
            seen.seconds             = req_bus.time_seconds;
            seen.microseconds        = req_bus.time_microseconds;
            seen.wire_length         = req_bus.wire_length;
            seen.header_words        = req_bus.header_words;
            seen.destination_address = req_bus.destination_address;
            sb.note_word(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] address_plan [4];
      packet_word_type   burst;
      int                n;
      sb = new;
      req_bus.valid               <= 1'b0;
      req_bus.action              <= ACTION_PACKET;
      req_bus.time_seconds        <= '0;
      req_bus.time_microseconds   <= '0;
      req_bus.wire_length         <= '0;
      req_bus.header_words        <= '0;
      req_bus.destination_address <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_local_address('0);
      send_word(make_flush());
      send_word(make_packet(32'd0, 20'd0, 16'd100, 4'd4, 32'd0));
      send_word(make_packet(32'd0, 20'd0, 16'd100, 4'd0, 32'd0));
      send_word(make_packet(32'd0, 20'd0, 16'd0, 4'd5, 32'd0));
      send_word(make_packet(32'd0, 20'd500, 16'hFFFF, 4'd15, 32'd0));
      send_word(make_packet(32'd0, 20'd10, 16'd64, 4'd5, 32'hFFFF_FFFF));
      send_word(make_packet(32'd0, 20'd999, 16'd1, 4'd5, 32'd0));
      send_word(make_packet(32'd0, 20'd1000, 16'd40, 4'd6, 32'd0));
      send_word(make_packet(32'd0, 20'd999999, 16'd1500, 4'd5, 32'd0));
      send_word(make_packet(32'd0, 20'hFFFFF, 16'd60, 4'd5, 32'd0));
      send_word(make_packet(32'd0, 20'd1000000, 16'd70, 4'd5, 32'd0));
      send_word(make_packet(32'hFFFF_FFFF, 20'd999999, 16'hFFFF, 4'd5, 32'd0));
      send_word(make_flush());
      send_word(make_flush());
      send_word(make_packet(32'hFFFF_FFFF, 20'd0, 16'd9, 4'd5, 32'd0));
      send_word(make_packet(32'h8000_0000, 20'h80000, 16'h8000, 4'd8, 32'h8000_0000));
      send_word(make_packet(32'hFFFF_FFFF, 20'd0, 16'd9, 4'd5, 32'd0));
      send_word(make_flush());
      wait_for_records();

      address_plan[0] = '1;
      address_plan[1] = $urandom();
      address_plan[2] = '0;
      address_plan[3] = $urandom();
      now_secs = $urandom();
      now_ms = 0;
      foreach (address_plan[p]) begin
         write_local_address(address_plan[p]);
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (n % 64 == 0) begin
               idle_on  = ($urandom_range(0, 3) != 0);
               stall_on = ($urandom_range(0, 3) != 0);
            end
            if (n == PHASE_WORDS / 2)
               wait_for_records();
            send_word(random_word());
         end
         wait_for_records();
      end

      // one bin of back-to-back full-size packets
      idle_on  = 1'b0;
      stall_on = 1'b0;
      burst = make_packet(32'h0000_1234, 20'd123456, 16'hFFFF, 4'd5, local_addr_now);
      for (n = 0; n < BURST_WORDS; n++)
         send_word(burst);
      send_word(make_flush());
      stall_on = 1'b1;
      send_word(make_packet(32'h0000_1235, 20'd7, 16'd3, 4'd5, local_addr_now));
      send_word(make_flush());
      wait_for_records();

      if (sb.failures == 0 && sb.pending_count() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
